FILE: hw/rtl/ray_ellipsoid_intersect_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ray/ellipsoid intersection block
// Shared concurrent-assertion forms with clock and async reset qualifiers.
// ----------------------------------------------------------------------------
`ifndef RAY_ELLIPSOID_INTERSECT_MACROS_SVH
`define RAY_ELLIPSOID_INTERSECT_MACROS_SVH

// same-cycle implication
`define REI_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rei: same-cycle check failed");

// next-cycle implication
`define REI_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rei: next-cycle check failed");

`endif

FILE: hw/rtl/rei_pkg.sv
// ----------------------------------------------------------------------------
// rei_pkg
// Widths, pipeline depths and shared types of the ray/ellipsoid block.
// ----------------------------------------------------------------------------
package rei_pkg;

    localparam int D_W    = 32;            // direction / coordinate
    localparam int RAD_W  = 31;
    localparam int M_W    = 34;            // origin minus centre
    localparam int R2_W   = 63;            // squared radius, signed container
    localparam int S_W    = 2 * R2_W;      // product of two squared radii
    localparam int DD_W   = 2 * D_W;
    localparam int MD_W   = M_W + D_W;
    localparam int MM_W   = 2 * M_W;
    localparam int P_W    = S_W + R2_W;
    localparam int TA_W   = S_W + DD_W;
    localparam int TB_W   = S_W + MD_W;
    localparam int TC_W   = S_W + MM_W;
    localparam int ABC_W  = 192;           // quadratic coefficients
    localparam int SQ_W   = 2 * ABC_W;
    localparam int DB_W   = ABC_W + D_W;
    localparam int DISC_W = SQ_W;
    localparam int X_W    = DISC_W + DD_W; // 4*d^2*disc
    localparam int ROOT_W = X_W / 2;
    localparam int K_W    = DB_W;
    localparam int DEN_W  = 190;
    localparam int Y_W    = K_W + 2;
    localparam int Q_W    = 32;
    localparam int OFF_W  = 32;

    // each layer waits for its slowest multiplier (one digit product per stage)
    localparam int LAT_L1   = 4;
    localparam int LAT_L2   = 12;
    localparam int LAT_L3   = 36;
    localparam int LAT_L4   = 24;
    // sqrt bits, y, magnitude, quotient bits, output register
    localparam int AXIS_LAT = ROOT_W + Q_W + 3;

    localparam logic signed [OFF_W-1:0] OFF_MAX = {1'b0, {(OFF_W-1){1'b1}}};
    localparam logic signed [OFF_W-1:0] OFF_MIN = {1'b1, {(OFF_W-1){1'b0}}};

    typedef struct packed {
        logic                     valid;
        logic                     miss;
        logic [2:0][D_W-1:0]      d;
    } rei_side_t;

endpackage

FILE: hw/rtl/rei_query_if.sv
// ----------------------------------------------------------------------------
// rei_query_if
// Ray query channel: origin, direction, ellipsoid centre and radii.
// ----------------------------------------------------------------------------
interface rei_query_if;

    logic               valid;
    logic               ready;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic [30:0]        radius_x;
    logic [30:0]        radius_y;
    logic [30:0]        radius_z;

    modport source (
        output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               centre_x, centre_y, centre_z, radius_x, radius_y, radius_z,
        input  ready
    );

    modport sink (
        input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               centre_x, centre_y, centre_z, radius_x, radius_y, radius_z,
        output ready
    );

endinterface

FILE: hw/rtl/rei_result_if.sv
// ----------------------------------------------------------------------------
// rei_result_if
// Intersection result channel: hit flag and origin-to-hit offset.
// ----------------------------------------------------------------------------
interface rei_result_if;

    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;

    modport source (
        output valid, hit, offset_x, offset_y, offset_z,
        input  ready
    );

    modport sink (
        input  valid, hit, offset_x, offset_y, offset_z,
        output ready
    );

endinterface

FILE: hw/rtl/rei_mul.sv
// ----------------------------------------------------------------------------
// rei_mul
// Pipelined signed multiplier: one 32x32 digit product per stage, fixed latency.
// ----------------------------------------------------------------------------
module rei_mul #(
    parameter int WA  = 32,
    parameter int WB  = 32,
    parameter int LAT = 1
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [WA-1:0]  a,
    input  logic signed [WB-1:0]  b,
    output logic signed [WA+WB-1:0] p
);

    localparam int NDA = (WA + 31) / 32;
    localparam int NDB = (WB + 31) / 32;
    localparam int NS  = NDA * NDB;
    localparam int WAX = NDA * 32;
    localparam int WBX = NDB * 32;
    localparam int WPX = WAX + WBX;
    localparam int WP  = WA + WB;

    logic signed [WPX-1:0] acc_reg [NS];
    logic signed [WAX-1:0] a_reg   [NS];
    logic signed [WBX-1:0] b_reg   [NS];

    for (genvar s = 0; s < NS; s++) begin : g_dig
        localparam int IA = s % NDA;
        localparam int IB = s / NDA;
        logic signed [WAX-1:0] a_in;
        logic signed [WBX-1:0] b_in;
        logic signed [WPX-1:0] acc_in;
        logic signed [32:0]    dig_a;
        logic signed [32:0]    dig_b;
        logic signed [65:0]    pp;
        logic signed [WPX-1:0] pp_ext;

        if (s == 0) begin : g_first
            assign a_in   = WAX'(a);
            assign b_in   = WBX'(b);
            assign acc_in = '0;
        end else begin : g_next
            assign a_in   = a_reg[s-1];
            assign b_in   = b_reg[s-1];
            assign acc_in = acc_reg[s-1];
        end

        // top digits carry the signs
        if (IA == NDA - 1) begin : g_top_a
            assign dig_a = {a_in[32*IA+31], a_in[32*IA +: 32]};
        end else begin : g_low_a
            assign dig_a = {1'b0, a_in[32*IA +: 32]};
        end

        if (IB == NDB - 1) begin : g_top_b
            assign dig_b = {b_in[32*IB+31], b_in[32*IB +: 32]};
        end else begin : g_low_b
            assign dig_b = {1'b0, b_in[32*IB +: 32]};
        end

        assign pp     = dig_a * dig_b;
        assign pp_ext = WPX'(pp);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[s] <= acc_in + (pp_ext <<< (32 * (IA + IB)));
                a_reg[s]   <= a_in;
                b_reg[s]   <= b_in;
            end
        end
    end

    if (LAT > NS) begin : g_pad
        logic signed [WP-1:0] pad_reg [LAT-NS];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pad_reg[0] <= acc_reg[NS-1][WP-1:0];
                for (int j = 1; j < LAT - NS; j++)
                begin
                    pad_reg[j] <= pad_reg[j-1];
                end
            end
        end

        assign p = pad_reg[LAT-NS-1];
    end else begin : g_nopad
        assign p = acc_reg[NS-1][WP-1:0];
    end

endmodule

FILE: hw/rtl/rei_axis.sv
// ----------------------------------------------------------------------------
// rei_axis
// Per-axis back end: exact integer sqrt, floor correction, bounded long
// division by 2a and saturation to the 32-bit offset.
// ----------------------------------------------------------------------------
module rei_axis
    import rei_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [X_W-1:0]          x,
    input  logic signed [K_W-1:0]   k,
    input  logic [DEN_W-1:0]        den,
    input  logic                    dpos,
    output logic signed [OFF_W-1:0] off
);

    localparam int XR_W = X_W + 1;

    // square root, one result bit per stage
    logic [XR_W-1:0]       srem_reg  [ROOT_W];
    logic [ROOT_W-1:0]     root_reg  [ROOT_W];
    logic signed [K_W-1:0] sk_reg    [ROOT_W];
    logic [DEN_W-1:0]      sden_reg  [ROOT_W];
    logic                  sdpos_reg [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_sqrt
        localparam int BIT = ROOT_W - 1 - s;
        logic [XR_W-1:0]       rem_in;
        logic [XR_W-1:0]       trial;
        logic [ROOT_W-1:0]     root_in;
        logic signed [K_W-1:0] k_in;
        logic [DEN_W-1:0]      den_in;
        logic                  dpos_in;

        if (s == 0) begin : g_first
            assign rem_in  = XR_W'(x);
            assign root_in = '0;
            assign k_in    = k;
            assign den_in  = den;
            assign dpos_in = dpos;
        end else begin : g_next
            assign rem_in  = srem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign k_in    = sk_reg[s-1];
            assign den_in  = sden_reg[s-1];
            assign dpos_in = sdpos_reg[s-1];
        end

        // (r + 2^j)^2 - r^2 = r*2^(j+1) + 2^(2j)
        assign trial = (XR_W'(root_in) << (BIT + 1)) | (XR_W'(1) << (2 * BIT));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= trial)
                begin
                    srem_reg[s] <= rem_in - trial;
                    root_reg[s] <= root_in | (ROOT_W'(1) << BIT);
                end
                else
                begin
                    srem_reg[s] <= rem_in;
                    root_reg[s] <= root_in;
                end
                sk_reg[s]    <= k_in;
                sden_reg[s]  <= den_in;
                sdpos_reg[s] <= dpos_in;
            end
        end
    end

    // floor of k -/+ sqrt(x)
    logic signed [Y_W-1:0] y_reg;
    logic [DEN_W-1:0]      yden_reg;
    logic                  exact;

    assign exact = (srem_reg[ROOT_W-1] == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (sdpos_reg[ROOT_W-1])
            begin
                y_reg <= Y_W'(sk_reg[ROOT_W-1]) - Y_W'(root_reg[ROOT_W-1])
                         - Y_W'(!exact);
            end
            else
            begin
                y_reg <= Y_W'(sk_reg[ROOT_W-1]) + Y_W'(root_reg[ROOT_W-1]);
            end
            yden_reg <= sden_reg[ROOT_W-1];
        end
    end

    // magnitude and range check ahead of the divider
    logic [Y_W-1:0]   mag_reg;
    logic [DEN_W-1:0] mden_reg;
    logic             mneg_reg;
    logic             movf_reg;
    logic [Y_W-1:0]   mag_next;

    assign mag_next = y_reg[Y_W-1] ? Y_W'(-y_reg) : Y_W'(y_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= mag_next;
            mden_reg <= yden_reg;
            mneg_reg <= y_reg[Y_W-1];
            movf_reg <= mag_next >= (Y_W'(yden_reg) << Q_W);
        end
    end

    // restoring division, one quotient bit per stage
    logic [Y_W-1:0]   drem_reg [Q_W];
    logic [Q_W-1:0]   q_reg    [Q_W];
    logic [DEN_W-1:0] dden_reg [Q_W];
    logic             dneg_reg [Q_W];
    logic             dovf_reg [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_div
        localparam int BIT = Q_W - 1 - s;
        logic [Y_W-1:0]   rem_in;
        logic [Y_W-1:0]   trial;
        logic [Q_W-1:0]   q_in;
        logic [DEN_W-1:0] den_in;
        logic             neg_in;
        logic             ovf_in;

        if (s == 0) begin : g_first
            assign rem_in = mag_reg;
            assign q_in   = '0;
            assign den_in = mden_reg;
            assign neg_in = mneg_reg;
            assign ovf_in = movf_reg;
        end else begin : g_next
            assign rem_in = drem_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign den_in = dden_reg[s-1];
            assign neg_in = dneg_reg[s-1];
            assign ovf_in = dovf_reg[s-1];
        end

        assign trial = Y_W'(den_in) << BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_in >= trial)
                begin
                    drem_reg[s] <= rem_in - trial;
                    q_reg[s]    <= q_in | (Q_W'(1) << BIT);
                end
                else
                begin
                    drem_reg[s] <= rem_in;
                    q_reg[s]    <= q_in;
                end
                dden_reg[s] <= den_in;
                dneg_reg[s] <= neg_in;
                dovf_reg[s] <= ovf_in;
            end
        end
    end

    // floor toward -inf for negative numerators, then saturate
    logic [Q_W-1:0]          q_fin;
    logic [Q_W:0]            q_up;
    logic                    neg_fin;
    logic signed [OFF_W-1:0] off_next;
    logic signed [OFF_W-1:0] off_reg;

    assign q_fin   = q_reg[Q_W-1];
    assign neg_fin = dneg_reg[Q_W-1];
    assign q_up    = {1'b0, q_fin} + (Q_W+1)'(neg_fin && (drem_reg[Q_W-1] != '0));

    always_comb
    begin
        if (dovf_reg[Q_W-1])
        begin
            off_next = neg_fin ? OFF_MIN : OFF_MAX;
        end
        else if (!neg_fin)
        begin
            off_next = q_fin[Q_W-1] ? OFF_MAX : OFF_W'(q_fin);
        end
        else if (q_up > {2'b01, {(Q_W-1){1'b0}}})
        begin
            off_next = OFF_MIN;
        end
        else
        begin
            off_next = OFF_W'(-q_up[Q_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            off_reg <= off_next;
        end
    end

    assign off = off_reg;

endmodule

FILE: hw/rtl/ray_ellipsoid_intersect.sv
// Throughput: one query per cycle unless the result side stalls; the multipliers
// (one 32x32 digit product per stage), the 224-stage exact square root and the
// 32-stage divider of each axis set the depth, every stage takes a new beat.
// A stall on the result side freezes the whole pipeline; nothing is dropped.
// Reset (rst_n, async, active low) clears only the valid/miss/direction side pipe.
// ----------------------------------------------------------------------------
// ray_ellipsoid_intersect
// Exact fixed-point ray line / axis-aligned ellipsoid intersection: smaller
// root, hit flag and saturated origin-to-hit offset.
// ----------------------------------------------------------------------------
`include "ray_ellipsoid_intersect_macros.svh"

module ray_ellipsoid_intersect
    import rei_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    rei_query_if.sink    query,
    rei_result_if.source result
);

    localparam int P_L1  = LAT_L1;
    localparam int P_L2  = P_L1 + LAT_L2;
    localparam int P_SUM = P_L2 + 1;
    localparam int P_L3  = P_SUM + LAT_L3;
    localparam int P_S4  = P_L3 + 1;
    localparam int P_L4  = P_S4 + LAT_L4;
    localparam int P_OUT = P_L4 + AXIS_LAT;

    logic en;

    assign en          = !result.valid || result.ready;
    assign query.ready = en;

    // ------------------------------------------------------------------
    // input stage
    // ------------------------------------------------------------------
    logic signed [D_W-1:0] org [3];
    logic signed [D_W-1:0] cen [3];
    logic signed [D_W-1:0] dir [3];
    logic [RAD_W-1:0]      rad [3];
    logic [R2_W-2:0]       r2sq [3];

    assign org[0] = query.origin_x;
    assign org[1] = query.origin_y;
    assign org[2] = query.origin_z;
    assign cen[0] = query.centre_x;
    assign cen[1] = query.centre_y;
    assign cen[2] = query.centre_z;
    assign dir[0] = query.dir_x;
    assign dir[1] = query.dir_y;
    assign dir[2] = query.dir_z;
    assign rad[0] = query.radius_x;
    assign rad[1] = query.radius_y;
    assign rad[2] = query.radius_z;

    logic signed [M_W-1:0]  m_reg  [3];
    logic signed [R2_W-1:0] r2_reg [3];
    rei_side_t              side_reg [P_OUT+1];
    rei_side_t              side_next;
    rei_side_t              side_s4;
    logic signed [DISC_W-1:0] disc_next;

    for (genvar i = 0; i < 3; i++) begin : g_in
        logic [RAD_W-1:0] rv;

        // zero radius counts as the smallest step
        assign rv      = (rad[i] == '0) ? RAD_W'(1) : rad[i];
        assign r2sq[i] = (R2_W-1)'(rv) * (R2_W-1)'(rv);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[i]  <= M_W'(org[i]) - M_W'(cen[i]);
                r2_reg[i] <= {1'b0, r2sq[i]};
            end
        end
    end

    always_comb
    begin
        side_next.valid = query.valid;
        side_next.miss  = (dir[0] == '0) && (dir[1] == '0) && (dir[2] == '0);
        for (int i = 0; i < 3; i++)
        begin
            side_next.d[i] = dir[i];
        end
    end

    // a negative discriminant joins the miss flag where the discriminant lands
    always_comb
    begin
        side_s4      = side_reg[P_S4-1];
        side_s4.miss = side_reg[P_S4-1].miss | disc_next[DISC_W-1];
    end

    // valid, miss and direction travel alongside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= P_OUT; j++)
            begin
                side_reg[j] <= '0;
            end
        end
        else if (en)
        begin
            side_reg[0] <= side_next;
            for (int j = 1; j <= P_OUT; j++)
            begin
                side_reg[j] <= (j == P_S4) ? side_s4 : side_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // layer 1: radius products, m*d products and per-axis squares
    // ------------------------------------------------------------------
    logic signed [S_W-1:0]  s_w  [3];
    logic signed [DD_W-1:0] dd_w [3];
    logic signed [MD_W-1:0] md_w [3];
    logic signed [MM_W-1:0] mm_w [3];

    for (genvar i = 0; i < 3; i++) begin : g_l1
        localparam int SA = (i == 0) ? 1 : 0;
        localparam int SB = (i == 2) ? 1 : 2;

        rei_mul #(.WA(R2_W), .WB(R2_W), .LAT(LAT_L1)) u_s (
            .clk (clk), .en (en), .a (r2_reg[SA]), .b (r2_reg[SB]), .p (s_w[i])
        );
        rei_mul #(.WA(D_W), .WB(D_W), .LAT(LAT_L1)) u_dd (
            .clk (clk), .en (en), .a ($signed(side_reg[0].d[i])),
            .b ($signed(side_reg[0].d[i])), .p (dd_w[i])
        );
        rei_mul #(.WA(M_W), .WB(D_W), .LAT(LAT_L1)) u_md (
            .clk (clk), .en (en), .a (m_reg[i]), .b ($signed(side_reg[0].d[i])),
            .p (md_w[i])
        );
        rei_mul #(.WA(M_W), .WB(M_W), .LAT(LAT_L1)) u_mm (
            .clk (clk), .en (en), .a (m_reg[i]), .b (m_reg[i]), .p (mm_w[i])
        );
    end

    logic signed [R2_W-1:0] r2x_dly [LAT_L1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2x_dly[0] <= r2_reg[0];
            for (int j = 1; j < LAT_L1; j++)
            begin
                r2x_dly[j] <= r2x_dly[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // layer 2: terms of a, b, c scaled by the radius products
    // ------------------------------------------------------------------
    logic signed [P_W-1:0]  p_w;
    logic signed [TA_W-1:0] ta_w [3];
    logic signed [TB_W-1:0] tb_w [3];
    logic signed [TC_W-1:0] tc_w [3];

    rei_mul #(.WA(S_W), .WB(R2_W), .LAT(LAT_L2)) u_p (
        .clk (clk), .en (en), .a (s_w[0]), .b (r2x_dly[LAT_L1-1]), .p (p_w)
    );

    for (genvar i = 0; i < 3; i++) begin : g_l2
        rei_mul #(.WA(S_W), .WB(DD_W), .LAT(LAT_L2)) u_ta (
            .clk (clk), .en (en), .a (s_w[i]), .b (dd_w[i]), .p (ta_w[i])
        );
        rei_mul #(.WA(S_W), .WB(MD_W), .LAT(LAT_L2)) u_tb (
            .clk (clk), .en (en), .a (s_w[i]), .b (md_w[i]), .p (tb_w[i])
        );
        rei_mul #(.WA(S_W), .WB(MM_W), .LAT(LAT_L2)) u_tc (
            .clk (clk), .en (en), .a (s_w[i]), .b (mm_w[i]), .p (tc_w[i])
        );
    end

    logic signed [ABC_W-1:0] a_reg;
    logic signed [ABC_W-1:0] b_reg;
    logic signed [ABC_W-1:0] c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= ABC_W'(ta_w[0]) + ABC_W'(ta_w[1]) + ABC_W'(ta_w[2]);
            b_reg <= ABC_W'(tb_w[0]) + ABC_W'(tb_w[1]) + ABC_W'(tb_w[2]);
            c_reg <= ABC_W'(tc_w[0]) + ABC_W'(tc_w[1]) + ABC_W'(tc_w[2])
                     - ABC_W'(p_w);
        end
    end

    // ------------------------------------------------------------------
    // layer 3: b^2, a*c and d*b
    // ------------------------------------------------------------------
    logic signed [SQ_W-1:0] bb_w;
    logic signed [SQ_W-1:0] ac_w;
    logic signed [DB_W-1:0] db_w [3];

    rei_mul #(.WA(ABC_W), .WB(ABC_W), .LAT(LAT_L3)) u_bb (
        .clk (clk), .en (en), .a (b_reg), .b (b_reg), .p (bb_w)
    );
    rei_mul #(.WA(ABC_W), .WB(ABC_W), .LAT(LAT_L3)) u_ac (
        .clk (clk), .en (en), .a (a_reg), .b (c_reg), .p (ac_w)
    );

    for (genvar i = 0; i < 3; i++) begin : g_l3
        rei_mul #(.WA(ABC_W), .WB(D_W), .LAT(LAT_L3)) u_db (
            .clk (clk), .en (en), .a (b_reg), .b ($signed(side_reg[P_SUM].d[i])),
            .p (db_w[i])
        );
    end

    logic signed [ABC_W-1:0] a_dly [LAT_L3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dly[0] <= a_reg;
            for (int j = 1; j < LAT_L3; j++)
            begin
                a_dly[j] <= a_dly[j-1];
            end
        end
    end

    // quarter discriminant and numerator base k = a - 2*d*b
    logic signed [DISC_W-1:0] disc_reg;
    logic signed [K_W-1:0]    k_reg  [3];
    logic signed [DD_W-1:0]   dd_reg [3];
    logic [DEN_W-1:0]         den_reg;

    assign disc_next = bb_w - ac_w;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            disc_reg <= disc_next;
            den_reg  <= DEN_W'(a_dly[LAT_L3-1]) << 1;
            for (int i = 0; i < 3; i++)
            begin
                k_reg[i]  <= K_W'(a_dly[LAT_L3-1]) - (db_w[i] <<< 1);
                dd_reg[i] <= $signed(side_reg[P_L3].d[i]) * $signed(side_reg[P_L3].d[i]);
            end
        end
    end

    // ------------------------------------------------------------------
    // layer 4: d^2 * disc, then the per-axis back ends
    // ------------------------------------------------------------------
    logic signed [X_W-1:0] xp_w [3];
    logic signed [K_W-1:0] k_dly [3][LAT_L4];
    logic [DEN_W-1:0]      den_dly [LAT_L4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_dly[0] <= den_reg;
            for (int j = 1; j < LAT_L4; j++)
            begin
                den_dly[j] <= den_dly[j-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                k_dly[i][0] <= k_reg[i];
                for (int j = 1; j < LAT_L4; j++)
                begin
                    k_dly[i][j] <= k_dly[i][j-1];
                end
            end
        end
    end

    logic signed [OFF_W-1:0] off_w [3];

    for (genvar i = 0; i < 3; i++) begin : g_axis
        logic [X_W-1:0] x_in;
        logic           dpos;
        logic [D_W-1:0] dv;

        rei_mul #(.WA(DISC_W), .WB(DD_W), .LAT(LAT_L4)) u_x (
            .clk (clk), .en (en), .a (disc_reg), .b (dd_reg[i]), .p (xp_w[i])
        );

        // a miss feeds zero so the square root stays in range
        assign x_in = side_reg[P_L4].miss ? '0 : (X_W'(xp_w[i]) << 2);
        assign dv   = side_reg[P_L4].d[i];
        assign dpos = !dv[D_W-1] && (dv != '0);

        rei_axis u_axis (
            .clk  (clk),
            .en   (en),
            .x    (x_in),
            .k    (k_dly[i][LAT_L4-1]),
            .den  (den_dly[LAT_L4-1]),
            .dpos (dpos),
            .off  (off_w[i])
        );
    end

    // ------------------------------------------------------------------
    // result beat
    // ------------------------------------------------------------------
    assign result.valid    = side_reg[P_OUT].valid;
    assign result.hit      = !side_reg[P_OUT].miss;
    assign result.offset_x = side_reg[P_OUT].miss ? '0 : off_w[0];
    assign result.offset_y = side_reg[P_OUT].miss ? '0 : off_w[1];
    assign result.offset_z = side_reg[P_OUT].miss ? '0 : off_w[2];

    // a nonzero direction makes a positive, so the divisor is never zero on a hit
    `REI_ASSERT_IMP(a_den_nonzero, clk, rst_n, side_reg[P_S4].valid && !side_reg[P_S4].miss, den_reg != '0)
    `REI_ASSERT_IMP(a_disc_hit, clk, rst_n, side_reg[P_S4].valid && !side_reg[P_S4].miss, !disc_reg[DISC_W-1])
    `REI_ASSERT_NXT(a_miss_kept, clk, rst_n, en && side_reg[P_S4].miss, side_reg[P_S4+1].miss)

endmodule
